FILE: rtl/core/acl_pkg.sv
// shared types, constants and pattern tables for the at response line classifier
// no dependencies; used by acl_match and at_response_line_classifier_core

package acl_pkg;

  localparam int unsigned LineMax = 128;
  localparam int unsigned CountW  = $clog2(LineMax);
  localparam int unsigned LenW    = 7;
  localparam int unsigned NumPat  = 11;
  localparam int unsigned NumPfx  = 3;
  localparam int unsigned StrW    = 88;

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPrompt = 8'h3E;

  localparam logic [CountW-1:0] CountLast = CountW'(LineMax - 1);
  localparam logic [LenW-1:0]   LenSat    = '1;

  // prefix patterns: once their whole text has been seen, the line matches them whatever follows
  localparam logic [NumPat-1:0] PrefixMask = 11'b000_0011_0100;

  typedef enum logic [3:0] {
    ClsText       = 4'd0,
    ClsOk         = 4'd1,
    ClsConnect    = 4'd2,
    ClsError      = 4'd3,
    ClsCme        = 4'd4,
    ClsCms        = 4'd5,
    ClsNoCarrier  = 4'd6,
    ClsNoDialtone = 4'd7,
    ClsBusy       = 4'd8,
    ClsNoAnswer   = 4'd9,
    ClsRing       = 4'd10,
    ClsPrompt     = 4'd11,
    ClsOverflow   = 4'd12
  } line_class_e;

  typedef struct packed {
    logic [NumPat-1:0] alive;
    logic [NumPfx-1:0] prefix;
    line_class_e       cls;
  } match_t;

  function automatic logic [StrW-1:0] pat_str(input int unsigned idx);
    logic [StrW-1:0] s;
    begin
      unique case (idx)
        0:       s = StrW'("OK");
        1:       s = StrW'("CONNECT");
        2:       s = StrW'("CONNECT ");
        3:       s = StrW'("ERROR");
        4:       s = StrW'("+CME ERROR");
        5:       s = StrW'("+CMS ERROR");
        6:       s = StrW'("NO CARRIER");
        7:       s = StrW'("NO DIALTONE");
        8:       s = StrW'("BUSY");
        9:       s = StrW'("NO ANSWER");
        default: s = StrW'("RING");
      endcase
      return s;
    end
  endfunction

  function automatic logic [3:0] pat_len(input int unsigned idx);
    logic [3:0] n;
    begin
      unique case (idx)
        0:       n = 4'd2;
        1:       n = 4'd7;
        2:       n = 4'd8;
        3:       n = 4'd5;
        4:       n = 4'd10;
        5:       n = 4'd10;
        6:       n = 4'd10;
        7:       n = 4'd11;
        8:       n = 4'd4;
        9:       n = 4'd9;
        default: n = 4'd4;
      endcase
      return n;
    end
  endfunction

  function automatic line_class_e pat_class(input int unsigned idx);
    line_class_e c;
    begin
      unique case (idx)
        0:       c = ClsOk;
        1:       c = ClsConnect;
        2:       c = ClsConnect;
        3:       c = ClsError;
        4:       c = ClsCme;
        5:       c = ClsCms;
        6:       c = ClsNoCarrier;
        7:       c = ClsNoDialtone;
        8:       c = ClsBusy;
        9:       c = ClsNoAnswer;
        default: c = ClsRing;
      endcase
      return c;
    end
  endfunction

  function automatic logic [1:0] pat_pfx(input int unsigned idx);
    logic [1:0] b;
    begin
      unique case (idx)
        4:       b = 2'd1;
        5:       b = 2'd2;
        default: b = 2'd0;
      endcase
      return b;
    end
  endfunction

  // character at position pos of a pattern; pos must be below its length
  function automatic logic [7:0] pat_char(input int unsigned idx, input logic [3:0] pos);
    logic [StrW-1:0] s;
    logic [3:0]      sh;
    begin
      s  = pat_str(idx);
      sh = 4'(pat_len(idx) - 4'd1 - pos);
      s  = s >> {sh, 3'b000};
      return s[7:0];
    end
  endfunction

endpackage

FILE: rtl/core/acl_match.sv
// per-byte pattern matcher: next alive and prefix bits, and line class of the current state
// depends on acl_pkg

module acl_match (
  input  logic [7:0]                   rx_byte_i,
  input  logic [acl_pkg::CountW-1:0]   count_i,
  input  logic [acl_pkg::NumPat-1:0]   alive_i,
  input  logic [acl_pkg::NumPfx-1:0]   prefix_i,
  output acl_pkg::match_t              match_o
);

  always_comb begin
    logic [acl_pkg::NumPat-1:0] alive;
    logic [acl_pkg::NumPfx-1:0] prefix;
    acl_pkg::line_class_e       cls;
    logic [1:0]                 pb;
    logic                       in_range;
    alive  = alive_i;
    prefix = prefix_i;
    cls    = acl_pkg::ClsText;
    for (int unsigned i = 0; i < acl_pkg::NumPat; i++) begin
      pb       = acl_pkg::pat_pfx(i);
      in_range = count_i < acl_pkg::CountW'(acl_pkg::pat_len(i));
      if (!(acl_pkg::PrefixMask[i] && prefix_i[pb]) && alive_i[i]) begin
        if (in_range && acl_pkg::pat_char(i, count_i[3:0]) == rx_byte_i) begin
          if (acl_pkg::PrefixMask[i] &&
              count_i == acl_pkg::CountW'(acl_pkg::pat_len(i) - 4'd1)) begin
            prefix[pb] = 1'b1;
          end
        end else begin
          alive[i] = 1'b0;
        end
      end
    end
    // classify, first pattern in list order wins
    for (int i = acl_pkg::NumPat - 1; i >= 0; i--) begin
      pb = acl_pkg::pat_pfx(i);
      if (acl_pkg::PrefixMask[i]) begin
        if (prefix_i[pb]) cls = acl_pkg::pat_class(i);
      end else if (alive_i[i] &&
                   count_i == acl_pkg::CountW'(acl_pkg::pat_len(i))) begin
        cls = acl_pkg::pat_class(i);
      end
    end
    match_o.alive  = alive;
    match_o.prefix = prefix;
    match_o.cls    = cls;
  end

endmodule

FILE: rtl/core/at_response_line_classifier_core.sv
// top level of the at response line classifier: input register, line state, result register
// depends on acl_pkg and acl_match

// Classifies modem response lines one received byte per beat. A byte taken on the
// input channel lands in the input register; when it moves on, it is matched against
// every pattern at once and the line state (character count, per-pattern alive bits,
// prefix bits, drop flag) is updated, and a finished line writes the result register.
// One byte per cycle is taken unless an output stall holds a result. CR bytes are
// ignored, an LF ends a non-empty line, and a byte arriving after LINE_MAX-1
// characters reports overflow and then drops bytes through the next LF.
// With prompt_enable set, a leading '>' reports a prompt at once. The input side
// stalls only while a result is waiting in the result register and the output is
// stalled. prompt_enable should only be written while the block is idle.

module at_response_line_classifier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       prompt_enable_we_i,
  input  logic       prompt_enable_i,
  // byte input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] line_class_o,
  output logic [6:0] line_len_o
);

  // configuration register
  logic prompt_en_q;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;

  // line state
  logic [acl_pkg::CountW-1:0] count_q, count_d;
  logic                       dropping_q, dropping_d;
  logic [acl_pkg::NumPat-1:0] alive_q, alive_d;
  logic [acl_pkg::NumPfx-1:0] prefix_q, prefix_d;

  // result register
  logic                     out_valid_q, out_valid_d;
  acl_pkg::line_class_e     class_q, class_d;
  logic [acl_pkg::LenW-1:0] length_q, length_d;

  logic            advance;
  logic            in_accept;
  logic            emit;
  logic            is_overflow;
  acl_pkg::match_t match;
  logic [acl_pkg::LenW-1:0] count_sat;

  // the byte in the input register moves on when the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign count_sat = (count_q > acl_pkg::CountW'(acl_pkg::LenSat)) ?
                     acl_pkg::LenSat : acl_pkg::LenW'(count_q);

  acl_match u_match (
    .rx_byte_i (byte_q),
    .count_i   (count_q),
    .alive_i   (alive_q),
    .prefix_i  (prefix_q),
    .match_o   (match)
  );

  always_comb begin
    count_d     = count_q;
    dropping_d  = dropping_q;
    alive_d     = alive_q;
    prefix_d    = prefix_q;
    emit        = 1'b0;
    is_overflow = 1'b0;
    class_d     = class_q;
    length_d    = length_q;
    if (advance) begin
      priority if (dropping_q) begin
        // discard until the line feed that ends the long line
        if (byte_q == acl_pkg::ChLf) begin
          dropping_d = 1'b0;
          count_d    = '0;
          alive_d    = '1;
          prefix_d   = '0;
        end
      end else if (byte_q == acl_pkg::ChCr) begin
        // carriage return carries nothing
      end else if (byte_q == acl_pkg::ChLf) begin
        if (count_q != '0) begin
          emit     = 1'b1;
          class_d  = match.cls;
          length_d = count_sat;
        end
        count_d  = '0;
        alive_d  = '1;
        prefix_d = '0;
      end else if (count_q >= acl_pkg::CountLast) begin
        // line too long: report and start dropping
        emit        = 1'b1;
        is_overflow = 1'b1;
        class_d     = acl_pkg::ClsOverflow;
        length_d    = count_sat;
        dropping_d  = 1'b1;
        count_d     = '0;
        alive_d     = '1;
        prefix_d    = '0;
      end else if (prompt_en_q && count_q == '0 && byte_q == acl_pkg::ChPrompt) begin
        // leading prompt reports at once and leaves an empty line
        emit     = 1'b1;
        class_d  = acl_pkg::ClsPrompt;
        length_d = acl_pkg::LenW'(1);
        count_d  = '0;
        alive_d  = '1;
        prefix_d = '0;
      end else begin
        count_d  = count_q + acl_pkg::CountW'(1);
        alive_d  = match.alive;
        prefix_d = match.prefix;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_en_q <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      dropping_q  <= 1'b0;
      alive_q     <= '1;
      prefix_q    <= '0;
    end else begin
      if (prompt_enable_we_i) begin
        prompt_en_q <= prompt_enable_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      dropping_q  <= dropping_d;
      alive_q     <= alive_d;
      prefix_q    <= prefix_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
    end
    class_q  <= class_d;
    length_q <= length_d;
  end

  assign out_valid_o  = out_valid_q;
  assign line_class_o = class_q;
  assign line_len_o   = length_q;

  // a prompt result always reports one character
  a_prompt_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_class_o == acl_pkg::ClsPrompt) |-> (line_len_o == 7'd1))
    else $error("prompt result with length other than one");

  // while dropping, the line state stays cleared
  a_drop_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropping_q |-> (count_q == '0 && prefix_q == '0 && alive_q == '1))
    else $error("line state not cleared while dropping");

  // overflow result is followed by drop mode
  a_ovf_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_overflow |=> (dropping_q && out_valid_o && line_class_o == acl_pkg::ClsOverflow))
    else $error("overflow did not enter drop mode");

  // character count never passes the overflow point
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= acl_pkg::CountLast)
    else $error("character count beyond line limit");

endmodule

FILE: sim/tb_at_response_line_classifier_core.sv
// testbench for at_response_line_classifier_core: byte stream in, line reports out
// depends on acl_pkg for the class enum and the character and length constants

module tb_at_response_line_classifier_core;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHold   = 80;

  typedef struct {
    acl_pkg::line_class_e cls;
    logic [6:0]           len;
  } line_report_t;

  logic       clk_i              = 1'b0;
  logic       rst_ni             = 1'b0;
  logic       prompt_enable_we_i = 1'b0;
  logic       prompt_enable_i    = 1'b0;
  logic       in_valid_i         = 1'b0;
  logic [7:0] rx_byte_i          = 8'h00;
  logic       out_stall_i        = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [3:0] line_class_o;
  logic [6:0] line_len_o;

  at_response_line_classifier_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .prompt_enable_we_i (prompt_enable_we_i),
    .prompt_enable_i    (prompt_enable_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .line_class_o       (line_class_o),
    .line_len_o         (line_len_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // keyword table in class priority order; prefix keywords carry their matched-bit index
  string kw_text [acl_pkg::NumPat] = '{"OK", "CONNECT", "CONNECT ", "ERROR", "+CME ERROR",
                                       "+CMS ERROR", "NO CARRIER", "NO DIALTONE", "BUSY",
                                       "NO ANSWER", "RING"};
  acl_pkg::line_class_e kw_class [acl_pkg::NumPat] = '{
    acl_pkg::ClsOk, acl_pkg::ClsConnect, acl_pkg::ClsConnect, acl_pkg::ClsError,
    acl_pkg::ClsCme, acl_pkg::ClsCms, acl_pkg::ClsNoCarrier, acl_pkg::ClsNoDialtone,
    acl_pkg::ClsBusy, acl_pkg::ClsNoAnswer, acl_pkg::ClsRing};
  int kw_pfx_bit [acl_pkg::NumPat] = '{-1, -1, 0, -1, 1, 2, -1, -1, -1, -1, -1};

  // shadow of the line state
  int unsigned               line_chars;
  bit                        drop_rest;
  bit [acl_pkg::NumPat-1:0]  kw_alive;
  bit [acl_pkg::NumPfx-1:0]  kw_pfx_seen;
  bit                        prompt_on;

  line_report_t owed_lines [$];
  logic [7:0]   tx_bytes [$];
  int unsigned  bytes_queued;
  int unsigned  errors;
  bit           no_idle;

  // long receiver hold-off, requested by the stimulus and counted here
  int unsigned hold_asks;
  int unsigned hold_served;
  int unsigned hold_left;

  task automatic clear_line();
    line_chars  = 0;
    kw_alive    = '1;
    kw_pfx_seen = '0;
  endtask

  // advance the shadow state by one accepted byte and queue any line report it causes
  task automatic classify_byte(input logic [7:0] b);
    line_report_t r;
    bit           emit;
    bit           found;
    begin
      emit  = 1'b0;
      r.len = (line_chars > 127) ? 7'd127 : 7'(line_chars);
      r.cls = acl_pkg::ClsText;
      if (drop_rest) begin
        // overflowed line: swallow everything through the line feed
        if (b == acl_pkg::ChLf) begin
          drop_rest = 1'b0;
          clear_line();
        end
      end else if (b == acl_pkg::ChCr) begin
        // carriage return never counts
      end else if (b == acl_pkg::ChLf) begin
        if (line_chars != 0) begin
          found = 1'b0;
          for (int i = 0; i < acl_pkg::NumPat; i++) begin
            if (!found) begin
              if (kw_pfx_bit[i] >= 0) begin
                if (kw_pfx_seen[kw_pfx_bit[i]]) begin
                  r.cls = kw_class[i];
                  found = 1'b1;
                end
              end else if (kw_alive[i] && line_chars == kw_text[i].len()) begin
                r.cls = kw_class[i];
                found = 1'b1;
              end
            end
          end
          clear_line();
          emit = 1'b1;
        end
      end else if (line_chars >= acl_pkg::LineMax - 1) begin
        r.cls = acl_pkg::ClsOverflow;
        clear_line();
        drop_rest = 1'b1;
        emit      = 1'b1;
      end else begin
        for (int i = 0; i < acl_pkg::NumPat; i++) begin
          if (kw_pfx_bit[i] >= 0 && kw_pfx_seen[kw_pfx_bit[i]]) continue;
          if (!kw_alive[i]) continue;
          if (line_chars < kw_text[i].len() && 8'(kw_text[i][line_chars]) == b) begin
            if (kw_pfx_bit[i] >= 0 && line_chars + 1 == kw_text[i].len())
              kw_pfx_seen[kw_pfx_bit[i]] = 1'b1;
          end else begin
            kw_alive[i] = 1'b0;
          end
        end
        line_chars++;
        // leading '>' reports right away when prompts are on
        if (prompt_on && line_chars == 1 && b == acl_pkg::ChPrompt) begin
          clear_line();
          r.cls = acl_pkg::ClsPrompt;
          r.len = 7'd1;
          emit  = 1'b1;
        end
      end
      if (emit) owed_lines.push_back(r);
    end
  endtask

  // sender: one beat per queued byte, random gap after each
  always @(posedge clk_i) begin : sender
    bit          free;
    int unsigned gap;
    if (rst_ni) begin
      free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        classify_byte(rx_byte_i);
        free = 1'b1;
      end
      if (free) begin
        if (gap != 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= tx_bytes.pop_front();
          gap = no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_left   <= LongHold;
      hold_served <= hold_served + 1;
    end
  end

  // receiver: check each report beat against the oldest owed line
  always @(posedge clk_i) begin : receiver
    int unsigned  wait_left;
    line_report_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_lines.size() == 0) begin
          $error("unexpected report: line_class %0d line_len %0d",
                 line_class_o, line_len_o);
          errors++;
        end else begin
          want = owed_lines.pop_front();
          if (line_class_o !== want.cls) begin
            $error("line_class expected %0d actual %0d", want.cls, line_class_o);
            errors++;
          end
          if (line_len_o !== want.len) begin
            $error("line_len expected %0d actual %0d", want.len, line_len_o);
            errors++;
          end
        end
        wait_left = no_idle ? 0 : $urandom_range(0, 9);
      end else if (wait_left != 0) begin
        wait_left--;
      end
      out_stall_i <= (hold_left != 0) || (wait_left != 0);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("FAIL at_response_line_classifier_core");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
  endtask

  task automatic push_line(input string s);
    push_text(s);
    if ($urandom_range(0, 2) == 0) push_byte(acl_pkg::ChCr);
    push_byte(acl_pkg::ChLf);
  endtask

  // mostly keyword-shaped lines with random damage, plus text, noise and odd lines
  task automatic push_random_line();
    string       s;
    string       near_abc;
    int unsigned kind;
    int unsigned sfx;
    begin
      near_abc = "ONCERIGBUSYADLT +M";
      s        = "";
      sfx      = 0;
      kind     = $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) begin
        // around the line limit: just under, exactly at, and past it
        repeat ($urandom_range(acl_pkg::LineMax - 4, acl_pkg::LineMax + 12))
          push_byte(8'($urandom_range(32, 126)));
      end else if (kind < 11) begin
        s = kw_text[$urandom_range(0, acl_pkg::NumPat - 1)];
        case ($urandom_range(0, 5))
          0: s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(32, 126)));
          1: s = s.substr(0, $urandom_range(0, s.len() - 2));
          2, 3: sfx = $urandom_range(1, 8);
          default: ;
        endcase
        push_text(s);
        repeat (sfx) push_byte(8'($urandom_range(32, 126)));
      end else if (kind < 14) begin
        repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(32, 126)));
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else if (kind < 18) begin
        push_byte(acl_pkg::ChPrompt);
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(32, 126)));
      end else if (kind == 19) begin
        repeat ($urandom_range(1, 11))
          push_byte(8'(near_abc[$urandom_range(0, near_abc.len() - 1)]));
      end
      // occasional stray carriage return before the end
      if ($urandom_range(0, 7) == 0) push_byte(acl_pkg::ChCr);
      if ($urandom_range(0, 2) == 0) push_byte(acl_pkg::ChCr);
      push_byte(acl_pkg::ChLf);
    end
  endtask

  // sender pause: everything sent, every report back, then the pipeline drained
  task automatic settle();
    while (tx_bytes.size() != 0 || in_valid_i || owed_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_prompt_enable(input bit v);
    @(posedge clk_i);
    prompt_enable_we_i <= 1'b1;
    prompt_enable_i    <= v;
    prompt_on = v;
    @(posedge clk_i);
    prompt_enable_we_i <= 1'b0;
  endtask

  initial begin
    string       plain_lines [$];
    int unsigned phase_start;
    plain_lines = '{"OK", "CONNECT", "CONNECT 9600", "ERROR", "+CME ERROR: 3",
                    "+CMS ERROR: 500", "NO CARRIER", "NO DIALTONE", "BUSY", "NO ANSWER",
                    "RING", "OKAY", "O", ">", "ATD>1"};
    clear_line();
    drop_rest = 1'b0;
    prompt_on = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, prompts off: every class but prompt, empty lines, extreme bytes, line limit
    write_prompt_enable(1'b0);
    foreach (plain_lines[i]) push_line(plain_lines[i]);
    push_byte(acl_pkg::ChLf);
    push_byte(acl_pkg::ChCr);
    push_byte(acl_pkg::ChLf);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(acl_pkg::ChLf);
    repeat (acl_pkg::LineMax - 1) push_byte("A");
    push_byte(acl_pkg::ChCr);
    push_byte(acl_pkg::ChLf);
    repeat (acl_pkg::LineMax - 1) push_byte("B");
    push_text("C>D");
    push_byte(acl_pkg::ChCr);
    push_byte(acl_pkg::ChLf);
    settle();

    // directed, prompts on: leading prompt, prompt after CR, prompt twice, prompt mid-line
    write_prompt_enable(1'b1);
    push_text(">");
    push_line("OK");
    push_byte(acl_pkg::ChCr);
    push_line(">");
    push_line(">>");
    push_line("a>");
    repeat (acl_pkg::LineMax + 2) push_byte(">");
    push_byte(acl_pkg::ChLf);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      write_prompt_enable(ph[0]);
      no_idle = (ph == 2);
      phase_start = bytes_queued;
      if (ph == 3) begin
        // back-to-back short lines while the receiver holds off: the block backs up
        repeat (40) push_line("OK");
        hold_asks++;
      end
      while (bytes_queued - phase_start < 200) push_random_line();
      settle();
    end

    if (errors == 0) begin
      $display("PASS at_response_line_classifier_core");
    end else begin
      $display("FAIL at_response_line_classifier_core");
    end
    $finish;
  end

endmodule
